### rtl/lcdseq_pkg.sv
// Shared types, codes and constants for the character LCD nibble sequencer.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lcdseq_pkg;

   // Request operations
   localparam logic [2:0] OP_INIT   = 3'd0;
   localparam logic [2:0] OP_CMD    = 3'd1;
   localparam logic [2:0] OP_CHAR   = 3'd2;
   localparam logic [2:0] OP_CURSOR = 3'd3;
   localparam logic [2:0] OP_PRINT  = 3'd4;

   // Configuration registers
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_HOLD  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_HOLD = 1'd1;
   localparam logic [15:0] LONG_HOLD_RESET  = 16'd2000;
   localparam logic [7:0]  SHORT_HOLD_RESET = 8'd20;

   // Cursor address
   localparam logic [7:0] CURSOR_BASE = 8'h80;
   localparam logic [7:0] ROW2_OFFSET = 8'h40;
   localparam logic [1:0] FIRST_ROW   = 2'd1;

   // Decimal print
   localparam int DECIMAL_DIGITS_DEFAULT = 5;
   localparam int BIN_W                  = 16;
   localparam int BCD_CNT_W              = $clog2(BIN_W + 1);
   localparam logic [3:0] DIGIT_HI_NIB   = 4'h3;  // '0' + d has high nibble 3

   // Microcode word
   localparam int UPC_W = 5;

   localparam logic [1:0] UK_SETTLE = 2'd0;  // single state, E low, long hold
   localparam logic [1:0] UK_NIB    = 2'd1;  // E-low, E-high, E-low triple
   localparam logic [1:0] UK_WAIT   = 2'd2;  // wait for the BCD converter

   localparam logic [1:0] NS_CONST   = 2'd0;
   localparam logic [1:0] NS_BYTE_HI = 2'd1;
   localparam logic [1:0] NS_BYTE_LO = 2'd2;
   localparam logic [1:0] NS_DIGIT   = 2'd3;

   localparam logic [1:0] SQ_NEXT  = 2'd0;
   localparam logic [1:0] SQ_END   = 2'd1;
   localparam logic [1:0] SQ_DLOOP = 2'd2;  // jump to target while digits remain

   // Program entry points
   localparam logic [UPC_W-1:0] ENTRY_INIT  = 5'd0;
   localparam logic [UPC_W-1:0] ENTRY_BYTE  = 5'd13;
   localparam logic [UPC_W-1:0] ENTRY_PRINT = 5'd15;
   localparam logic [UPC_W-1:0] DIGIT_LOOP  = 5'd16;

   typedef struct packed {
      logic [1:0]       kind;
      logic [1:0]       nsrc;
      logic [3:0]       cnib;
      logic [1:0]       seq;
      logic [UPC_W-1:0] target;
   } ucode_word_type;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] value;
      logic [1:0]  row;
      logic [4:0]  column;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]  data_nibble;
      logic        reg_select;
      logic        enable;
      logic [15:0] hold_us;
      logic        last;
   } rsp_payload_type;

endpackage

`default_nettype wire

### rtl/lcdseq_ucode_rom.sv
// Microcode store for the LCD sequencer: one control word per program step.
// Depends on lcdseq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_ucode_rom
   import lcdseq_pkg::*;
(
   input  wire logic [UPC_W-1:0] addr,
   output ucode_word_type        word
);

   function automatic ucode_word_type uw(input logic [1:0] kind, input logic [1:0] nsrc,
                                         input logic [3:0] cnib, input logic [1:0] seq,
                                         input logic [UPC_W-1:0] target);
      ucode_word_type w;
      w.kind   = kind;
      w.nsrc   = nsrc;
      w.cnib   = cnib;
      w.seq    = seq;
      w.target = target;
      return w;
   endfunction

   always_comb begin
      unique case (addr)
         // init: settle, 3 x 0x3, 0x2, then 0x28 0x0C 0x01 0x06
         5'd0:    word = uw(UK_SETTLE, NS_CONST, 4'h0, SQ_NEXT, ENTRY_INIT);
         5'd1:    word = uw(UK_NIB, NS_CONST, 4'h3, SQ_NEXT, ENTRY_INIT);
         5'd2:    word = uw(UK_NIB, NS_CONST, 4'h3, SQ_NEXT, ENTRY_INIT);
         5'd3:    word = uw(UK_NIB, NS_CONST, 4'h3, SQ_NEXT, ENTRY_INIT);
         5'd4:    word = uw(UK_NIB, NS_CONST, 4'h2, SQ_NEXT, ENTRY_INIT);
         5'd5:    word = uw(UK_NIB, NS_CONST, 4'h2, SQ_NEXT, ENTRY_INIT);
         5'd6:    word = uw(UK_NIB, NS_CONST, 4'h8, SQ_NEXT, ENTRY_INIT);
         5'd7:    word = uw(UK_NIB, NS_CONST, 4'h0, SQ_NEXT, ENTRY_INIT);
         5'd8:    word = uw(UK_NIB, NS_CONST, 4'hC, SQ_NEXT, ENTRY_INIT);
         5'd9:    word = uw(UK_NIB, NS_CONST, 4'h0, SQ_NEXT, ENTRY_INIT);
         5'd10:   word = uw(UK_NIB, NS_CONST, 4'h1, SQ_NEXT, ENTRY_INIT);
         5'd11:   word = uw(UK_NIB, NS_CONST, 4'h0, SQ_NEXT, ENTRY_INIT);
         5'd12:   word = uw(UK_NIB, NS_CONST, 4'h6, SQ_END, ENTRY_INIT);
         // command, character and cursor: one byte from the byte register
         5'd13:   word = uw(UK_NIB, NS_BYTE_HI, 4'h0, SQ_NEXT, ENTRY_INIT);
         5'd14:   word = uw(UK_NIB, NS_BYTE_LO, 4'h0, SQ_END, ENTRY_INIT);
         // decimal print
         5'd15:   word = uw(UK_WAIT, NS_CONST, 4'h0, SQ_NEXT, ENTRY_INIT);
         5'd16:   word = uw(UK_NIB, NS_CONST, DIGIT_HI_NIB, SQ_NEXT, ENTRY_INIT);
         5'd17:   word = uw(UK_NIB, NS_DIGIT, 4'h0, SQ_DLOOP, DIGIT_LOOP);
         default: word = uw(UK_WAIT, NS_CONST, 4'h0, SQ_END, ENTRY_INIT);
      endcase
   end

endmodule

`default_nettype wire

### rtl/lcdseq_bcd.sv
// Iterative binary to BCD converter (shift and add 3, one bit per cycle)
// with a digit shifter for reading the result most significant first.
// Depends on lcdseq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_bcd
   import lcdseq_pkg::*;
#(
   parameter int DECIMAL_DIGITS = DECIMAL_DIGITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [BIN_W-1:0] bin_value,
   input  wire logic             shift_digit,
   output logic                  busy,
   output logic [3:0]            digit
);

   localparam int BCD_W = 4 * DECIMAL_DIGITS;

   logic [BCD_W-1:0]     bcd_ff, bcd_in, bcd_adj;
   logic [BIN_W-1:0]     bin_ff, bin_in;
   logic [BCD_CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      for (int i = 0; i < DECIMAL_DIGITS; i++) begin
         if (bcd_ff[4*i +: 4] >= 4'd5) begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4] + 4'd3;
         end else begin
            bcd_adj[4*i +: 4] = bcd_ff[4*i +: 4];
         end
      end
   end

   always_comb begin
      bcd_in = bcd_ff;
      bin_in = bin_ff;
      cnt_in = cnt_ff;
      if (start) begin
         bcd_in = '0;
         bin_in = bin_value;
         cnt_in = BCD_CNT_W'(BIN_W);
      end else if (cnt_ff != '0) begin
         bcd_in = {bcd_adj[BCD_W-2:0], bin_ff[BIN_W-1]};
         bin_in = {bin_ff[BIN_W-2:0], 1'b0};
         cnt_in = cnt_ff - BCD_CNT_W'(1);
      end else if (shift_digit) begin
         bcd_in = {bcd_ff[BCD_W-5:0], 4'h0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      bcd_ff <= bcd_in;
      bin_ff <= bin_in;
   end

   assign busy  = (cnt_ff != '0);
   assign digit = bcd_ff[BCD_W-1 -: 4];

endmodule

`default_nettype wire

### rtl/char_lcd_nibble_sequencer.sv
// Top level of the character LCD nibble sequencer: step counter, datapath,
// output register. Depends on lcdseq_pkg, lcdseq_ucode_rom and lcdseq_bcd.
`timescale 1ns / 1ps
`default_nettype none

// Turns one request into a run of pin states for a 4-bit character LCD bus, one
// pin state per clock while rsp_stall is low. Init gives 37 states; command,
// character and cursor requests give 6; a decimal print gives 6 per digit
// (DECIMAL_DIGITS digits, leading zeros) after a binary to BCD conversion.
// The pace is set by the microcode step counter, one state per cycle while
// rsp_stall is low, plus the bit-serial BCD unit for prints. The next request
// is taken in the cycle after the last state of the current one has entered
// the output register. Operation codes 5 to 7 are taken and give no states.
// Hold times come from the two configuration registers.
module char_lcd_nibble_sequencer
   import lcdseq_pkg::*;
#(
   parameter int DECIMAL_DIGITS = DECIMAL_DIGITS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire req_payload_type        req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output rsp_payload_type             rsp_payload,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int DIG_CNT_W = $clog2(DECIMAL_DIGITS + 1);

   logic [15:0]          long_hold_ff;
   logic [7:0]           short_hold_ff;
   logic                 busy_ff, busy_in;
   logic [UPC_W-1:0]     upc_ff, upc_in;
   logic [1:0]           phase_ff, phase_in;
   logic                 rs_ff, rs_in;
   logic [7:0]           byte_ff, byte_in;
   logic [DIG_CNT_W-1:0] digits_ff, digits_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_payload_ff, rsp_payload_in;

   ucode_word_type cw;
   logic           req_accept, out_free, advance, emit, word_done, is_last;
   logic           bcd_busy, bcd_start, bcd_shift;
   logic [3:0]     bcd_digit, nib;
   logic [7:0]     cursor_addr;

   lcdseq_ucode_rom u_rom (
      .addr (upc_ff),
      .word (cw)
   );

   lcdseq_bcd #(
      .DECIMAL_DIGITS (DECIMAL_DIGITS)
   ) u_bcd (
      .clock       (clock),
      .reset       (reset),
      .start       (bcd_start),
      .bin_value   (req_payload.value),
      .shift_digit (bcd_shift),
      .busy        (bcd_busy),
      .digit       (bcd_digit)
   );

   assign req_stall  = busy_ff;
   assign req_accept = req_valid && !busy_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign bcd_start  = req_accept && (req_payload.operation == OP_PRINT);

   always_comb begin
      cursor_addr = CURSOR_BASE + {3'b000, req_payload.column} - 8'd1;
      if (req_payload.row != FIRST_ROW) begin
         cursor_addr = cursor_addr + ROW2_OFFSET;
      end
   end

   // step control
   always_comb begin
      if (cw.kind == UK_WAIT) begin
         advance = busy_ff && !bcd_busy;
      end else begin
         advance = busy_ff && out_free;
      end
      emit      = advance && (cw.kind != UK_WAIT);
      word_done = advance && ((cw.kind != UK_NIB) || (phase_ff == 2'd2));
      is_last   = (cw.kind == UK_NIB) && (phase_ff == 2'd2) &&
                  ((cw.seq == SQ_END) || ((cw.seq == SQ_DLOOP) && (digits_ff == DIG_CNT_W'(1))));
      bcd_shift = word_done && (cw.seq == SQ_DLOOP);
   end

   always_comb begin
      busy_in   = busy_ff;
      upc_in    = upc_ff;
      phase_in  = phase_ff;
      rs_in     = rs_ff;
      byte_in   = byte_ff;
      digits_in = digits_ff;
      if (req_accept) begin
         phase_in  = 2'd0;
         digits_in = DIG_CNT_W'(DECIMAL_DIGITS);
         byte_in   = req_payload.value[7:0];
         busy_in   = 1'b1;
         case (req_payload.operation)
            OP_INIT: begin
               upc_in = ENTRY_INIT;
               rs_in  = 1'b0;
            end
            OP_CMD: begin
               upc_in = ENTRY_BYTE;
               rs_in  = 1'b0;
            end
            OP_CHAR: begin
               upc_in = ENTRY_BYTE;
               rs_in  = 1'b1;
            end
            OP_CURSOR: begin
               upc_in  = ENTRY_BYTE;
               rs_in   = 1'b0;
               byte_in = cursor_addr;
            end
            OP_PRINT: begin
               upc_in = ENTRY_PRINT;
               rs_in  = 1'b1;
            end
            default: begin
               busy_in = 1'b0;  // unknown operation: dropped
            end
         endcase
      end else if (word_done) begin
         phase_in = 2'd0;
         case (cw.seq)
            SQ_NEXT: upc_in = upc_ff + UPC_W'(1);
            SQ_DLOOP: begin
               if (digits_ff > DIG_CNT_W'(1)) begin
                  upc_in    = cw.target;
                  digits_in = digits_ff - DIG_CNT_W'(1);
               end else begin
                  busy_in = 1'b0;
               end
            end
            default: busy_in = 1'b0;
         endcase
      end else if (emit) begin
         phase_in = phase_ff + 2'd1;
      end
   end

   // pin state datapath
   always_comb begin
      case (cw.nsrc)
         NS_BYTE_HI: nib = byte_ff[7:4];
         NS_BYTE_LO: nib = byte_ff[3:0];
         NS_DIGIT:   nib = bcd_digit;
         default:    nib = cw.cnib;
      endcase
      rsp_payload_in.data_nibble = nib;
      rsp_payload_in.reg_select  = (cw.kind == UK_NIB) && rs_ff;
      rsp_payload_in.enable      = (cw.kind == UK_NIB) && (phase_ff == 2'd1);
      if ((cw.kind == UK_NIB) && (phase_ff != 2'd2)) begin
         rsp_payload_in.hold_us = {8'h00, short_hold_ff};
      end else begin
         rsp_payload_in.hold_us = long_hold_ff;
      end
      rsp_payload_in.last = is_last;

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_hold_ff  <= LONG_HOLD_RESET;
         short_hold_ff <= SHORT_HOLD_RESET;
         busy_ff       <= 1'b0;
         upc_ff        <= ENTRY_INIT;
         phase_ff      <= 2'd0;
         digits_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we && (csr_index == CSR_LONG_HOLD)) begin
            long_hold_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_SHORT_HOLD)) begin
            short_hold_ff <= csr_wdata[7:0];
         end
         busy_ff      <= busy_in;
         upc_ff       <= upc_in;
         phase_ff     <= phase_in;
         digits_ff    <= digits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rs_ff   <= rs_in;
      byte_ff <= byte_in;
      if (emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

### rtl/lcdseq_checker.sv
// Port-level checks for char_lcd_nibble_sequencer, attached by bind.
// Depends on lcdseq_pkg and the top level.
`timescale 1ns / 1ps
`default_nettype none

module lcdseq_checker
   import lcdseq_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_valid,
   input wire logic            req_stall,
   input wire logic            rsp_valid,
   input wire logic            rsp_stall,
   input wire rsp_payload_type rsp_payload
);

   // a stalled result stays put
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // within a request, pin states follow each other without gaps
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_payload.last |=> rsp_valid)
      else $error("gap inside a pin state run");

   // a new request is only taken once the last state is out
   a_ready_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(req_stall) |-> rsp_valid && rsp_payload.last)
      else $error("request port reopened before the final pin state");

   // every run ends with enable low
   a_last_enable_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.last |-> !rsp_payload.enable)
      else $error("final pin state has enable high");

   // a transfer on the request side never happens during an open run
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && rsp_valid && !rsp_payload.last |-> 1'b0)
      else $error("request taken in the middle of a pin state run");

endmodule

bind char_lcd_nibble_sequencer lcdseq_checker u_lcdseq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
